/* src/bedq_pkg.sv */
// ----------------------------------------------------------------------------
// bedq_pkg
// Shared types and codes for the button event detector with its event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bedq_pkg;

  // request operations
  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // queue entry codes
  localparam logic [2:0] CODE_NONE      = 3'd0;
  localparam logic [2:0] CODE_DOWN      = 3'd1;
  localparam logic [2:0] CODE_UP        = 3'd2;
  localparam logic [2:0] CODE_LONG      = 3'd3;
  localparam logic [2:0] CODE_LONG_LONG = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONGER_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLE = 2'd2;

  // register reset values
  localparam logic [7:0] LONG_TICKS_RESET   = 8'd40;
  localparam logic [7:0] LONGER_TICKS_RESET = 8'd80;
  localparam logic       QUEUE_ENABLE_RESET = 1'b1;

  localparam logic [7:0] HOLD_MAX = 8'hff;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  // scan result bits, msb first: long, long-long, up, down
  typedef struct packed {
    logic long_ev;
    logic long_long;
    logic up;
    logic down;
  } flags_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       pin_level;
  } req_t;

  typedef struct packed {
    logic [3:0] event_flags;
    logic [2:0] read_event;
  } rsp_t;

  // queue commands for one accepted beat
  typedef struct packed {
    logic push;
    logic get;
    logic peek;
    logic flush;
  } queue_cmd_t;

endpackage

`default_nettype wire

/* src/button_event_detector_with_queue.sv */
// ----------------------------------------------------------------------------
// button_event_detector_with_queue
// Button debounce, long-press detection and a ring queue of button events.
// ----------------------------------------------------------------------------
// Every request beat (scan tick, get, peek or flush) gives exactly one registered
// response beat; a new request is taken every cycle while req_stall is low.
// The whole step is one pass of logic from the state registers and the
// request into the response register, and a second response register lets a
// request be taken while the first result still waits downstream, so the
// request side stalls only when both are full. The queue holds QUEUE_DEPTH
// codes in flip-flops; a scan tick can write up to three of them at once.
// Entries never written since reset read back as unspecified codes.
`default_nettype none

module button_event_detector_with_queue import bedq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output rsp_t                       rsp,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] long_ticks;
  logic [7:0] longer_ticks;
  logic       queue_enable;

  logic       accept;
  logic       take;
  logic       skid_valid;
  rsp_t       skid;
  rsp_t       result;
  flags_t     flags;
  queue_cmd_t qcmd;
  logic [2:0] read_event;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign take      = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks   <= LONG_TICKS_RESET;
      longer_ticks <= LONGER_TICKS_RESET;
      queue_enable <= QUEUE_ENABLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LONG_TICKS:   long_ticks   <= cfg_data[7:0];
        REG_LONGER_TICKS: longer_ticks <= cfg_data[7:0];
        REG_QUEUE_ENABLE: queue_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bedq_detect u_detect (
    .clk          (clk),
    .rst          (rst),
    .tick         (accept && req.operation == OP_SCAN),
    .pressed      (!req.pin_level),
    .long_ticks   (long_ticks),
    .longer_ticks (longer_ticks),
    .flags        (flags)
  );

  always_comb begin
    qcmd       = '0;
    qcmd.push  = accept && req.operation == OP_SCAN && queue_enable && (flags != '0);
    qcmd.get   = accept && req.operation == OP_GET;
    qcmd.peek  = accept && req.operation == OP_PEEK;
    qcmd.flush = accept && req.operation == OP_FLUSH;
  end

  bedq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .cmd        (qcmd),
    .flags      (flags),
    .read_event (read_event)
  );

  always_comb begin
    result.event_flags = (req.operation == OP_SCAN) ? flags : 4'd0;
    result.read_event  = read_event;
  end

  // response register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!rsp_valid || take) begin
        rsp <= result;
      end else begin
        skid <= result;
      end
    end else if (take && skid_valid) begin
      rsp <= skid;
    end
  end

endmodule

`default_nettype wire

/* src/bedq_detect.sv */
// ----------------------------------------------------------------------------
// bedq_detect
// Debounce and hold tracking for one active-low button, one step per scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bedq_detect import bedq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       tick,
  input  wire logic       pressed,
  input  wire logic [7:0] long_ticks,
  input  wire logic [7:0] longer_ticks,
  output flags_t          flags
);

  logic       last_pressed;
  logic       down_valid;
  logic       down_reported;
  logic       long_seen;
  logic [7:0] hold_count;

  logic       down_valid_next;
  logic       down_reported_next;
  logic       long_seen_next;
  logic [7:0] hold_count_next;

  always_comb begin
    flags              = '0;
    down_valid_next    = down_valid;
    down_reported_next = down_reported;
    long_seen_next     = long_seen;
    hold_count_next    = hold_count;
    if (pressed) begin
      hold_count_next = (hold_count == HOLD_MAX) ? HOLD_MAX : hold_count + 8'd1;
      if (!long_seen && hold_count_next == long_ticks) begin
        long_seen_next = 1'b1;
        flags.long_ev  = 1'b1;
      end
      // a saturated counter does not move, so no repeat long-long
      if (long_seen_next && hold_count_next != hold_count &&
          hold_count_next == longer_ticks) begin
        flags.long_long = 1'b1;
      end
      if (last_pressed) begin
        down_valid_next = 1'b1;
        if (!down_reported) begin
          down_reported_next = 1'b1;
          flags.down         = 1'b1;
        end
      end
    end else begin
      down_reported_next = 1'b0;
      hold_count_next    = '0;
      if (down_valid) begin
        down_valid_next = 1'b0;
        long_seen_next  = 1'b0;
        flags.up        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed  <= 1'b0;
      down_valid    <= 1'b0;
      down_reported <= 1'b0;
      long_seen     <= 1'b0;
      hold_count    <= '0;
    end else if (tick) begin
      last_pressed  <= pressed;
      down_valid    <= down_valid_next;
      down_reported <= down_reported_next;
      long_seen     <= long_seen_next;
      hold_count    <= hold_count_next;
    end
  end

endmodule

`default_nettype wire

/* src/bedq_queue.sv */
// ----------------------------------------------------------------------------
// bedq_queue
// Ring of event codes with a write pointer and separate get and peek pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module bedq_queue import bedq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire queue_cmd_t cmd,
  input  wire flags_t     flags,
  output logic [2:0]      read_event
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  logic [2:0]       store [QUEUE_DEPTH];
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] peek_ptr;

  logic [PTR_W-1:0] slot_down;
  logic [PTR_W-1:0] slot_long;
  logic [PTR_W-1:0] slot_long_long;
  logic [PTR_W-1:0] after_long;
  logic [PTR_W-1:0] write_ptr_next;
  logic [PTR_W-1:0] sel_ptr;
  logic [PTR_W-1:0] sel_ptr_next;
  logic             empty;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  // up never shares a tick with the others; down, long, long-long pack in order
  always_comb begin
    slot_down      = write_ptr;
    slot_long      = flags.down ? next_slot(write_ptr) : write_ptr;
    slot_long_long = flags.long_ev ? next_slot(slot_long) : slot_long;
    after_long     = flags.long_long ? next_slot(slot_long_long) : slot_long_long;
    write_ptr_next = flags.up ? next_slot(write_ptr) : after_long;
  end

  always_comb begin
    sel_ptr      = cmd.peek ? peek_ptr : read_ptr;
    empty        = (sel_ptr == write_ptr);
    sel_ptr_next = next_slot(sel_ptr);
    read_event   = CODE_NONE;
    if ((cmd.get || cmd.peek) && !empty) begin
      read_event = store[sel_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (flags.down) begin
        store[slot_down] <= CODE_DOWN;
      end
      if (flags.up) begin
        store[slot_down] <= CODE_UP;
      end
      if (flags.long_ev) begin
        store[slot_long] <= CODE_LONG;
      end
      if (flags.long_long) begin
        store[slot_long_long] <= CODE_LONG_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      peek_ptr  <= '0;
    end else if (cmd.flush) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      peek_ptr  <= '0;
    end else begin
      if (cmd.push) begin
        write_ptr <= write_ptr_next;
      end
      if (cmd.get && !empty) begin
        read_ptr <= sel_ptr_next;
      end
      if (cmd.peek && !empty) begin
        peek_ptr <= sel_ptr_next;
      end
    end
  end

endmodule

`default_nettype wire

/* src/bedq_checker.sv */
// ----------------------------------------------------------------------------
// bedq_checker
// Port-level checks for the button event detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bedq_checker import bedq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // requests back up only behind a waiting response
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no response pending");

  // a beat carries scan flags or a read code, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.event_flags == 4'd0 || rsp.read_event == CODE_NONE))
    else $error("response carries both scan flags and a read code");

  // a release tick reports up alone
  a_up_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.event_flags[1] |-> rsp.event_flags == 4'b0010)
    else $error("up flag together with another event");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind button_event_detector_with_queue bedq_checker u_bedq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
